// File: rtl/sqe_pkg.sv
// shared types, constants and helpers of the shadow quad extruder
// no dependencies; used by the channel interfaces, the extrusion lane and the top level
package sqe_pkg;

  localparam int CORNERS    = 4;
  localparam int FRAC_BITS  = 16;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  // lane register count: 6 prep stages, root, multiply, round, divide, output
  localparam int LANE_LAT   = 6 + SQRT_STEPS + 2 + DIV_STEPS + 1;
  localparam int ADDR_W     = 5;

  typedef logic signed [31:0] coord_t;
  typedef logic [30:0]        mag31_t;
  typedef logic [20:0]        scale_t;

  localparam scale_t SCALE_RST   = 21'd65536;
  localparam mag31_t EXTRUDE_RST = 31'd58982400;

  typedef enum logic [2:0] {
    REG_SCALE   = 3'd0,
    REG_CAM_X   = 3'd1,
    REG_CAM_Y   = 3'd2,
    REG_LIGHT_X = 3'd3,
    REG_LIGHT_Y = 3'd4,
    REG_EXTRUDE = 3'd5
  } cfg_reg_t;

  // per-point context carried down the extrusion lane
  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   neg_x;
    logic   neg_y;
    logic   zero;
    mag31_t nx;
    mag31_t ny;
  } lane_ctx_t;

  typedef struct packed {
    coord_t     ax;
    coord_t     ay;
    coord_t     bx;
    coord_t     by;
    coord_t     cx;
    coord_t     cy;
    logic [1:0] edge_index;
    logic       half;
    logic       last;
  } tri_t;

  function automatic coord_t sat50(input logic signed [49:0] v);
    coord_t res;
    if (v[49:31] == {19{v[49]}}) res = v[31:0];
    else res = v[49] ? 32'sh80000000 : 32'sh7fffffff;
    return res;
  endfunction

  function automatic coord_t sat34(input logic signed [33:0] v);
    coord_t res;
    if (v[33:31] == {3{v[33]}}) res = v[31:0];
    else res = v[33] ? 32'sh80000000 : 32'sh7fffffff;
    return res;
  endfunction

endpackage

// File: rtl/sqe_in_if.sv
// input channel of the shadow quad extruder: one sprite rectangle per transaction
// depends on sqe_pkg
interface sqe_in_if;
  import sqe_pkg::*;

  logic   valid;
  logic   ready;
  coord_t inst_x;
  coord_t inst_y;
  mag31_t rect_w;
  mag31_t rect_h;
  coord_t anchor_x;
  coord_t anchor_y;

  modport source (output valid, inst_x, inst_y, rect_w, rect_h, anchor_x, anchor_y,
                  input ready);
  modport sink (input valid, inst_x, inst_y, rect_w, rect_h, anchor_x, anchor_y,
                output ready);
endinterface

// File: rtl/sqe_out_if.sv
// result channel of the shadow quad extruder: one shadow triangle per transaction
// depends on sqe_pkg
interface sqe_out_if;
  import sqe_pkg::*;

  logic       valid;
  logic       ready;
  coord_t     ax;
  coord_t     ay;
  coord_t     bx;
  coord_t     by;
  coord_t     cx;
  coord_t     cy;
  logic [1:0] edge_index;
  logic       half;
  logic       last;

  modport source (output valid, ax, ay, bx, by, cx, cy, edge_index, half, last,
                  input ready);
  modport sink (input valid, ax, ay, bx, by, cx, cy, edge_index, half, last,
                output ready);
endinterface

// File: rtl/sqe_lane.sv
// extrusion lane: pushes one point away from the light by the extrusion length
// depends on sqe_pkg; pipelined normalize, square root and two restoring dividers
module sqe_lane (
  input  logic            clk,
  input  logic            en,
  input  sqe_pkg::coord_t light_x,
  input  sqe_pkg::coord_t light_y,
  input  sqe_pkg::mag31_t extrude_len,
  input  sqe_pkg::coord_t px_i,
  input  sqe_pkg::coord_t py_i,
  output sqe_pkg::coord_t px_o,
  output sqe_pkg::coord_t py_o,
  output sqe_pkg::coord_t fx_o,
  output sqe_pkg::coord_t fy_o
);
  import sqe_pkg::*;

  // distance to the light
  logic signed [32:0] dx_r, dy_r;
  coord_t             p1x_r, p1y_r;
  // magnitudes
  logic [32:0]        ax2_r, ay2_r, m2_r;
  logic               sx2_r, sy2_r;
  coord_t             p2x_r, p2y_r;
  // leading one position
  logic [5:0]         pos3_r;
  logic [32:0]        ax3_r, ay3_r;
  logic               sx3_r, sy3_r, z3_r;
  coord_t             p3x_r, p3y_r;
  logic [5:0]         pos_w;
  // normalized
  lane_ctx_t          c4_r, c5_r, mc_r;
  logic [5:0]         rsh_w, lsh_w;
  logic [32:0]        nx_w, ny_w;
  logic [61:0]        sqx_r, sqy_r;
  // root and divide pipelines
  logic [63:0]        sq_n_r [0:SQRT_STEPS];
  logic [63:0]        sq_q_r [0:SQRT_STEPS];
  lane_ctx_t          sq_c_r [0:SQRT_STEPS];
  logic [61:0]        mx_r, my_r;
  logic [31:0]        mlen_r;
  logic [63:0]        dv_x_r [0:DIV_STEPS];
  logic [63:0]        dv_y_r [0:DIV_STEPS];
  logic [31:0]        dq_x_r [0:DIV_STEPS];
  logic [31:0]        dq_y_r [0:DIV_STEPS];
  logic [31:0]        dlen_r [0:DIV_STEPS];
  lane_ctx_t          dc_r   [0:DIV_STEPS];
  // output
  coord_t             fx_r, fy_r, pox_r, poy_r;
  logic signed [33:0] qx_s, qy_s, sumx_w, sumy_w;
  lane_ctx_t          fc_w;

  always_comb begin
    pos_w = '0;
    for (int i = 0; i < 33; i++) begin
      if (m2_r[i]) pos_w = 6'(i);
    end
  end

  assign rsh_w = pos3_r - 6'd30;
  assign lsh_w = 6'd30 - pos3_r;
  assign nx_w  = (pos3_r > 6'd30) ? (ax3_r >> rsh_w) : (ax3_r << lsh_w);
  assign ny_w  = (pos3_r > 6'd30) ? (ay3_r >> rsh_w) : (ay3_r << lsh_w);

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= 33'(px_i) - 33'(light_x);
      dy_r  <= 33'(py_i) - 33'(light_y);
      p1x_r <= px_i;
      p1y_r <= py_i;

      ax2_r <= dx_r[32] ? 33'(~dx_r + 33'sd1) : 33'(dx_r);
      ay2_r <= dy_r[32] ? 33'(~dy_r + 33'sd1) : 33'(dy_r);
      m2_r  <= (dx_r[32] ? 33'(~dx_r + 33'sd1) : 33'(dx_r)) >
               (dy_r[32] ? 33'(~dy_r + 33'sd1) : 33'(dy_r)) ?
               (dx_r[32] ? 33'(~dx_r + 33'sd1) : 33'(dx_r)) :
               (dy_r[32] ? 33'(~dy_r + 33'sd1) : 33'(dy_r));
      sx2_r <= dx_r[32];
      sy2_r <= dy_r[32];
      p2x_r <= p1x_r;
      p2y_r <= p1y_r;

      pos3_r <= pos_w;
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
      sx3_r  <= sx2_r;
      sy3_r  <= sy2_r;
      z3_r   <= (m2_r == '0);
      p3x_r  <= p2x_r;
      p3y_r  <= p2y_r;

      c4_r.px    <= p3x_r;
      c4_r.py    <= p3y_r;
      c4_r.neg_x <= sx3_r;
      c4_r.neg_y <= sy3_r;
      c4_r.zero  <= z3_r;
      c4_r.nx    <= nx_w[30:0];
      c4_r.ny    <= ny_w[30:0];

      sqx_r <= c4_r.nx * c4_r.nx;
      sqy_r <= c4_r.ny * c4_r.ny;
      c5_r  <= c4_r;

      sq_n_r[0] <= {2'b00, sqx_r} + {2'b00, sqy_r};
      sq_q_r[0] <= '0;
      sq_c_r[0] <= c5_r;
    end
  end

  // digit-by-digit square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [63:0] bit_w, trial_w;
    assign bit_w   = 64'd1 << (62 - 2 * k);
    assign trial_w = sq_q_r[k] + bit_w;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_c_r[k+1] <= sq_c_r[k];
        if (sq_n_r[k] >= trial_w) begin
          sq_n_r[k+1] <= sq_n_r[k] - trial_w;
          sq_q_r[k+1] <= (sq_q_r[k] >> 1) + bit_w;
        end else begin
          sq_n_r[k+1] <= sq_n_r[k];
          sq_q_r[k+1] <= sq_q_r[k] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r   <= sq_c_r[SQRT_STEPS].nx * extrude_len;
      my_r   <= sq_c_r[SQRT_STEPS].ny * extrude_len;
      mlen_r <= sq_q_r[SQRT_STEPS][31:0];
      mc_r   <= sq_c_r[SQRT_STEPS];

      // round half up: add half the divisor
      dv_x_r[0] <= {2'b00, mx_r} + 64'(mlen_r[31:1]);
      dv_y_r[0] <= {2'b00, my_r} + 64'(mlen_r[31:1]);
      dq_x_r[0] <= '0;
      dq_y_r[0] <= '0;
      dlen_r[0] <= mlen_r;
      dc_r[0]   <= mc_r;
    end
  end

  // restoring divide, quotient below 2^32
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [63:0] dsh_w;
    assign dsh_w = 64'(dlen_r[k]) << (DIV_STEPS - 1 - k);
    always_ff @(posedge clk) begin
      if (en) begin
        dlen_r[k+1] <= dlen_r[k];
        dc_r[k+1]   <= dc_r[k];
        if (dv_x_r[k] >= dsh_w) begin
          dv_x_r[k+1] <= dv_x_r[k] - dsh_w;
          dq_x_r[k+1] <= {dq_x_r[k][30:0], 1'b1};
        end else begin
          dv_x_r[k+1] <= dv_x_r[k];
          dq_x_r[k+1] <= {dq_x_r[k][30:0], 1'b0};
        end
        if (dv_y_r[k] >= dsh_w) begin
          dv_y_r[k+1] <= dv_y_r[k] - dsh_w;
          dq_y_r[k+1] <= {dq_y_r[k][30:0], 1'b1};
        end else begin
          dv_y_r[k+1] <= dv_y_r[k];
          dq_y_r[k+1] <= {dq_y_r[k][30:0], 1'b0};
        end
      end
    end
  end

  assign fc_w   = dc_r[DIV_STEPS];
  assign qx_s   = $signed({2'b00, dq_x_r[DIV_STEPS]});
  assign qy_s   = $signed({2'b00, dq_y_r[DIV_STEPS]});
  assign sumx_w = 34'(fc_w.px) + (fc_w.neg_x ? -qx_s : qx_s);
  assign sumy_w = 34'(fc_w.py) + (fc_w.neg_y ? -qy_s : qy_s);

  always_ff @(posedge clk) begin
    if (en) begin
      // point on the light stays where it is
      fx_r  <= fc_w.zero ? fc_w.px : sat34(sumx_w);
      fy_r  <= fc_w.zero ? fc_w.py : sat34(sumy_w);
      pox_r <= fc_w.px;
      poy_r <= fc_w.py;
    end
  end

  assign px_o = pox_r;
  assign py_o = poy_r;
  assign fx_o = fx_r;
  assign fy_o = fy_r;

endmodule

// File: rtl/shadow_quad_extruder_2d.sv
// top level of the 2d shadow quad extruder: front end, four extrusion lanes, triangle emitter
// depends on sqe_pkg, sqe_in_if, sqe_out_if and sqe_lane
//
// Takes one sprite rectangle per transaction, maps it to screen space (scale, camera,
// anchor), forms its four corners and emits two shadow triangles for each edge that
// faces the light, near triangle then far triangle, edges in order top, right, bottom,
// left; a rectangle with no such edge yields nothing. The datapath is a single pipeline
// that takes a new rectangle every cycle while not frozen: six front-end stages, then four
// parallel extrusion lanes of 73 stages each (normalize, one root bit per stage, multiply,
// round, one quotient bit per stage, output). Throughput is set by the single result port,
// one triangle per cycle while the sink is ready; a rectangle is held until its last
// triangle has been emitted. A stall on the result side freezes the whole pipeline once
// a rectangle is held, and nothing is lost. Registers sit on an APB-style port at byte
// address 4*i and should only be written while the block is idle.
module shadow_quad_extruder_2d (
  input  logic                         clk,
  input  logic                         rst_n,
  sqe_in_if.sink                       in_ch,
  sqe_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sqe_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import sqe_pkg::*;

  typedef struct packed {
    coord_t     p1x;
    coord_t     p1y;
    coord_t     p2x;
    coord_t     p2y;
    coord_t     f1x;
    coord_t     f1y;
    coord_t     f2x;
    coord_t     f2y;
    logic [1:0] idx;
  } edge_slot_t;

  // configuration registers
  scale_t   scale_r;
  coord_t   cam_x_r, cam_y_r, light_x_r, light_y_r;
  mag31_t   ext_r;
  cfg_reg_t reg_sel;
  logic     cfg_wr;

  // front end
  logic               adv;
  logic [5:0]         fv_r;
  coord_t             ix_r, iy_r, anx1_r, any1_r, anx2_r, any2_r, anx3_r, any3_r;
  mag31_t             rw_r, rh_r, w3_r, h3_r, w4_r, h4_r, w5_r, h5_r;
  logic signed [53:0] pxs_r, pys_r;
  logic [51:0]        pw_r, ph_r;
  logic signed [37:0] sx3_r, sy3_r;
  logic signed [63:0] aw4_r, ah4_r;
  logic signed [38:0] sxc4_r, syc4_r;
  logic signed [49:0] x05_r, y05_r;
  coord_t             cx0_r, cx1_r, cy0_r, cy2_r;
  logic [3:0]         qual_w;

  // lanes and side band
  coord_t             lin_x [CORNERS];
  coord_t             lin_y [CORNERS];
  coord_t             lp_x  [CORNERS];
  coord_t             lp_y  [CORNERS];
  coord_t             lf_x  [CORNERS];
  coord_t             lf_y  [CORNERS];
  logic               side_v_r [0:LANE_LAT-1];
  logic [3:0]         side_q_r [0:LANE_LAT-1];

  // emitter
  logic               hold_v_r;
  logic [1:0]         tri_r, last_r;
  edge_slot_t         slot_r [2];
  logic [1:0]         e0_w, e1_w;
  logic               f0_w, f1_w;
  logic               emit, hold_free;
  edge_slot_t         cur_w;
  tri_t               tri_w, out_r;
  logic               out_v_r;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= SCALE_RST;
      cam_x_r   <= '0;
      cam_y_r   <= '0;
      light_x_r <= '0;
      light_y_r <= '0;
      ext_r     <= EXTRUDE_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SCALE:   scale_r   <= pwdata[20:0];
        REG_CAM_X:   cam_x_r   <= pwdata;
        REG_CAM_Y:   cam_y_r   <= pwdata;
        REG_LIGHT_X: light_x_r <= pwdata;
        REG_LIGHT_Y: light_y_r <= pwdata;
        REG_EXTRUDE: ext_r     <= pwdata[30:0];
        default: ;  // unused addresses ignore writes
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SCALE:   prdata = 32'(scale_r);
      REG_CAM_X:   prdata = cam_x_r;
      REG_CAM_Y:   prdata = cam_y_r;
      REG_LIGHT_X: prdata = light_x_r;
      REG_LIGHT_Y: prdata = light_y_r;
      REG_EXTRUDE: prdata = 32'(ext_r);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- front end
  // the whole pipeline moves together whenever the emitter can take the oldest item
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) fv_r <= '0;
    else if (adv) fv_r <= {fv_r[4:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: capture the transaction
      ix_r   <= in_ch.inst_x;
      iy_r   <= in_ch.inst_y;
      rw_r   <= in_ch.rect_w;
      rh_r   <= in_ch.rect_h;
      anx1_r <= in_ch.anchor_x;
      any1_r <= in_ch.anchor_y;
      // stage 2: scale position and size
      pxs_r  <= ix_r * $signed({1'b0, scale_r});
      pys_r  <= iy_r * $signed({1'b0, scale_r});
      pw_r   <= rw_r * scale_r;
      ph_r   <= rh_r * scale_r;
      anx2_r <= anx1_r;
      any2_r <= any1_r;
      // stage 3: drop the fraction (floor), clamp size to 31 bits
      sx3_r  <= pxs_r[53:FRAC_BITS];
      sy3_r  <= pys_r[53:FRAC_BITS];
      w3_r   <= (pw_r[51:47] != '0) ? '1 : pw_r[46:FRAC_BITS];
      h3_r   <= (ph_r[51:47] != '0) ? '1 : ph_r[46:FRAC_BITS];
      anx3_r <= anx2_r;
      any3_r <= any2_r;
      // stage 4: anchor offset product, camera subtract
      aw4_r  <= anx3_r * $signed({1'b0, w3_r});
      ah4_r  <= any3_r * $signed({1'b0, h3_r});
      sxc4_r <= 39'(sx3_r) - 39'(cam_x_r);
      syc4_r <= 39'(sy3_r) - 39'(cam_y_r);
      w4_r   <= w3_r;
      h4_r   <= h3_r;
      // stage 5: top-left corner, unsaturated
      x05_r  <= 50'(sxc4_r) - 50'($signed(aw4_r[63:FRAC_BITS]));
      y05_r  <= 50'(syc4_r) - 50'($signed(ah4_r[63:FRAC_BITS]));
      w5_r   <= w4_r;
      h5_r   <= h4_r;
      // stage 6: saturated corner coordinates
      cx0_r  <= sat50(x05_r);
      cy0_r  <= sat50(y05_r);
      cx1_r  <= sat50(x05_r + $signed({19'b0, w5_r}));
      cy2_r  <= sat50(y05_r + $signed({19'b0, h5_r}));
    end
  end

  // edge facing test, edges are axis aligned so only signs matter;
  // a saturated corner can collapse an edge, which then never qualifies
  assign qual_w[0] = (cx1_r > cx0_r) && (cy0_r > light_y_r);
  assign qual_w[1] = (cy2_r > cy0_r) && (cx1_r < light_x_r);
  assign qual_w[2] = (cx1_r > cx0_r) && (cy2_r < light_y_r);
  assign qual_w[3] = (cy2_r > cy0_r) && (cx0_r > light_x_r);

  // corners: top-left, top-right, bottom-right, bottom-left
  assign lin_x[0] = cx0_r;
  assign lin_y[0] = cy0_r;
  assign lin_x[1] = cx1_r;
  assign lin_y[1] = cy0_r;
  assign lin_x[2] = cx1_r;
  assign lin_y[2] = cy2_r;
  assign lin_x[3] = cx0_r;
  assign lin_y[3] = cy2_r;

  // ---------------------------------------------------------------- extrusion lanes
  for (genvar c = 0; c < CORNERS; c++) begin : g_lane
    sqe_lane u_lane (
      .clk         (clk),
      .en          (adv),
      .light_x     (light_x_r),
      .light_y     (light_y_r),
      .extrude_len (ext_r),
      .px_i        (lin_x[c]),
      .py_i        (lin_y[c]),
      .px_o        (lp_x[c]),
      .py_o        (lp_y[c]),
      .fx_o        (lf_x[c]),
      .fy_o        (lf_y[c])
    );
  end

  // valid and facing mask ride alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) side_v_r[i] <= 1'b0;
    end else if (adv) begin
      side_v_r[0] <= fv_r[5];
      for (int i = 1; i < LANE_LAT; i++) side_v_r[i] <= side_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q_r[0] <= qual_w;
      for (int i = 1; i < LANE_LAT; i++) side_q_r[i] <= side_q_r[i-1];
    end
  end

  // ---------------------------------------------------------------- triangle emitter
  // pick the first two facing edges in order
  always_comb begin
    e0_w = '0;
    e1_w = '0;
    f0_w = 1'b0;
    f1_w = 1'b0;
    for (int i = 0; i < CORNERS; i++) begin
      if (side_q_r[LANE_LAT-1][i]) begin
        if (!f0_w) begin
          e0_w = 2'(i);
          f0_w = 1'b1;
        end else if (!f1_w) begin
          e1_w = 2'(i);
          f1_w = 1'b1;
        end
      end
    end
  end

  assign emit      = hold_v_r && (!out_v_r || out_ch.ready);
  assign hold_free = !hold_v_r || (emit && (tri_r == last_r));
  assign adv       = hold_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      tri_r    <= '0;
      last_r   <= '0;
    end else if (adv) begin
      hold_v_r <= side_v_r[LANE_LAT-1] && f0_w;
      tri_r    <= '0;
      last_r   <= f1_w ? 2'd3 : 2'd1;
    end else if (emit) begin
      tri_r <= tri_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slot_r[0].p1x <= lp_x[e0_w];
      slot_r[0].p1y <= lp_y[e0_w];
      slot_r[0].p2x <= lp_x[e0_w + 2'd1];
      slot_r[0].p2y <= lp_y[e0_w + 2'd1];
      slot_r[0].f1x <= lf_x[e0_w];
      slot_r[0].f1y <= lf_y[e0_w];
      slot_r[0].f2x <= lf_x[e0_w + 2'd1];
      slot_r[0].f2y <= lf_y[e0_w + 2'd1];
      slot_r[0].idx <= e0_w;
      slot_r[1].p1x <= lp_x[e1_w];
      slot_r[1].p1y <= lp_y[e1_w];
      slot_r[1].p2x <= lp_x[e1_w + 2'd1];
      slot_r[1].p2y <= lp_y[e1_w + 2'd1];
      slot_r[1].f1x <= lf_x[e1_w];
      slot_r[1].f1y <= lf_y[e1_w];
      slot_r[1].f2x <= lf_x[e1_w + 2'd1];
      slot_r[1].f2y <= lf_y[e1_w + 2'd1];
      slot_r[1].idx <= e1_w;
    end
  end

  // near triangle (p1, p2, far1), far triangle (p2, far2, far1)
  always_comb begin
    cur_w            = slot_r[tri_r[1]];
    tri_w.edge_index = cur_w.idx;
    tri_w.half       = tri_r[0];
    tri_w.last       = (tri_r == last_r);
    tri_w.cx         = cur_w.f1x;
    tri_w.cy         = cur_w.f1y;
    if (!tri_r[0]) begin
      tri_w.ax = cur_w.p1x;
      tri_w.ay = cur_w.p1y;
      tri_w.bx = cur_w.p2x;
      tri_w.by = cur_w.p2y;
    end else begin
      tri_w.ax = cur_w.p2x;
      tri_w.ay = cur_w.p2y;
      tri_w.bx = cur_w.f2x;
      tri_w.by = cur_w.f2y;
    end
  end

  // output register, next triangle loads while the current one is taken
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (emit) out_v_r <= 1'b1;
    else if (out_ch.ready) out_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) out_r <= tri_w;
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.ax         = out_r.ax;
  assign out_ch.ay         = out_r.ay;
  assign out_ch.bx         = out_r.bx;
  assign out_ch.by         = out_r.by;
  assign out_ch.cx         = out_r.cx;
  assign out_ch.cy         = out_r.cy;
  assign out_ch.edge_index = out_r.edge_index;
  assign out_ch.half       = out_r.half;
  assign out_ch.last       = out_r.last;

  // ---------------------------------------------------------------- assertions
  // a held rectangle always carries two or four triangles
  a_tri_count: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> (last_r == 2'd1 || last_r == 2'd3))
    else $error("held rectangle with bad triangle count");

  a_tri_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> tri_r <= last_r)
    else $error("triangle counter ran past the last triangle");

  // a near triangle is never the final one of a rectangle
  a_near_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.half |-> !out_r.last)
    else $error("near triangle flagged as last");

  a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r && last_r == 2'd3 |-> slot_r[0].idx < slot_r[1].idx)
    else $error("edges out of order");

  // a non-final triangle keeps the rectangle held and steps the counter
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    emit && tri_r != last_r |=> hold_v_r && tri_r == $past(tri_r) + 2'd1)
    else $error("emitter lost its place");

endmodule
